// ----- sv/wbs_pkg.sv -----
// ============================================================================
// wbs_pkg
// Shared types and constants of the word break segmenter: request and result
// payloads, opcodes, cell control groups and default sizes.
// ============================================================================
`default_nettype none

package wbs_pkg;

    // default sizes for the top level parameters
    localparam int MAX_WORDS_DEF    = 16;
    localparam int MAX_WORD_LEN_DEF = 16;

    // request opcodes
    typedef enum logic [1:0] {
        OP_DICT  = 2'd0,
        OP_TEXT  = 2'd1,
        OP_CLEAR = 2'd2
    } wbs_op_t;

    // one request
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] symbol;
        logic       last;
    } wbs_in_t;

    // one result
    typedef struct packed {
        logic prefix_breakable;
        logic text_end;
        logic dict_error;
    } wbs_out_t;

    // controls of a word cell
    typedef struct packed {
        logic load;
        logic commit;
        logic clear;
    } wbs_word_ctrl_t;

    // controls of a text position cell
    typedef struct packed {
        logic shift;
        logic clear;
    } wbs_pos_ctrl_t;

endpackage

`default_nettype wire

// ----- sv/wbs_pos_cell.sv -----
// ============================================================================
// wbs_pos_cell
// One text position: holds a recent text byte and whether the text position
// it closes was reachable; takes both from its neighbour on every text byte.
// ============================================================================
`default_nettype none

module wbs_pos_cell #(
    parameter bit START = 1'b0
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire wbs_pkg::wbs_pos_ctrl_t ctrl,
    input  wire logic [7:0]            byte_in,
    input  wire logic                  reach_in,
    output logic      [7:0]            byte_q,
    output logic                       reach_q
);

    logic [7:0] byte_reg;
    logic       reach_reg;

    // shift stage, cleared at text end and on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg  <= 8'd0;
            reach_reg <= START;
        end
        else if (ctrl.clear)
        begin
            byte_reg  <= 8'd0;
            reach_reg <= START;
        end
        else if (ctrl.shift)
        begin
            byte_reg  <= byte_in;
            reach_reg <= reach_in;
        end
    end

    assign byte_q  = byte_reg;
    assign reach_q = reach_reg;

endmodule

`default_nettype wire

// ----- sv/wbs_word_cell.sv -----
// ============================================================================
// wbs_word_cell
// One dictionary slot: bytes are shifted in newest first, so the stored word
// lines up with the text window and every byte compares at a fixed place.
// ============================================================================
`default_nettype none

module wbs_word_cell #(
    parameter  int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF,
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1)
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire wbs_pkg::wbs_word_ctrl_t          ctrl,
    input  wire logic [7:0]                       byte_in,
    input  wire logic [LEN_W-1:0]                 commit_len,
    input  wire logic [MAX_WORD_LEN-1:0][7:0]     window,
    input  wire logic [MAX_WORD_LEN-1:0]          reach,
    output logic                                  hit
);

    logic [MAX_WORD_LEN-1:0][7:0] chars_reg;
    logic [LEN_W-1:0]             len_reg;
    logic [MAX_WORD_LEN-1:0]      byte_ok;
    logic                         start_reached;

    // byte shift line, newest byte at position zero
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            chars_reg[0] <= byte_in;
            for (int j = 1; j < MAX_WORD_LEN; j++)
            begin
                chars_reg[j] <= chars_reg[j-1];
            end
        end
    end

    // committed length, zero means empty slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else if (ctrl.clear)
        begin
            len_reg <= '0;
        end
        else if (ctrl.commit)
        begin
            len_reg <= commit_len;
        end
    end

    // per position compare and reachability of the word start
    always_comb
    begin
        start_reached = 1'b0;
        for (int j = 0; j < MAX_WORD_LEN; j++)
        begin
            byte_ok[j] = (chars_reg[j] == window[j]) || (LEN_W'(j) >= len_reg);
            if (len_reg == LEN_W'(j + 1))
            begin
                start_reached = reach[j];
            end
        end
        hit = (len_reg != '0) && (&byte_ok) && start_reached;
    end

endmodule

`default_nettype wire

// ----- sv/word_break_segmenter.sv -----
// ============================================================================
// word_break_segmenter
// Streams dictionary words and text bytes and tells, per text byte, whether
// the text so far splits into dictionary words.
// ============================================================================
// Requests arrive on item (valid/ready); results leave on result
// (valid/ready). A dictionary byte is stored in the slot being loaded; with
// last set it yields one result whose dict_error says if the word was dropped
// (longer than MAX_WORD_LEN, or the store already holds MAX_WORDS words).
// A text byte yields one result; last set ends the text and restores the
// start position. Clear empties dictionary and text state, no result.
// One request is taken per cycle while the skid stage is empty. A result is
// registered in the output register, or in the skid stage while that waits.
// Every word cell compares its slot against the text window in parallel,
// and the hits are or-ed into the reach bit that the position cells shift
// on, all combinationally; that loop sets the clock.
// The result register is backed by a one-entry skid stage, so a request is
// still taken while one result waits; item_ready falls only when both hold
// results. After reset the dictionary is empty and the text is at its start;
// no clearing pass is needed.
// ============================================================================
`default_nettype none

module word_break_segmenter #(
    parameter int MAX_WORDS    = wbs_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire wbs_pkg::wbs_in_t  item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output wbs_pkg::wbs_out_t      result
);

    localparam int CNT_W = $clog2(MAX_WORDS + 1);
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);

    logic                         accept;
    logic                         is_dict;
    logic                         is_text;
    logic                         is_clear;
    logic                         room;
    logic                         store;
    logic                         ovf_after;
    logic                         commit;
    logic                         push;
    logic                         reached;
    logic [LEN_W-1:0]             len_after;
    logic [CNT_W-1:0]             word_count_reg;
    logic [CNT_W-1:0]             word_count_next;
    logic [LEN_W-1:0]             load_len_reg;
    logic [LEN_W-1:0]             load_len_next;
    logic                         load_ovf_reg;
    logic                         load_ovf_next;
    logic [MAX_WORD_LEN-1:0][7:0] text_q;
    logic [MAX_WORD_LEN-1:0]      reach_q;
    logic [MAX_WORD_LEN-1:0][7:0] window;
    logic [MAX_WORDS-1:0]         hits;
    wbs_pkg::wbs_pos_ctrl_t       pos_ctrl;
    wbs_pkg::wbs_out_t            new_res;
    wbs_pkg::wbs_out_t            out_reg;
    wbs_pkg::wbs_out_t            out_next;
    wbs_pkg::wbs_out_t            skid_reg;
    wbs_pkg::wbs_out_t            skid_next;
    logic                         out_vld_reg;
    logic                         out_vld_next;
    logic                         skid_vld_reg;
    logic                         skid_vld_next;
    logic                         out_pop;

    // request decode and word loading bookkeeping
    always_comb
    begin
        accept   = item_valid && item_ready;
        is_dict  = 1'b0;
        is_text  = 1'b0;
        is_clear = 1'b0;
        case (item.opcode)
            wbs_pkg::OP_DICT:  is_dict  = accept;
            wbs_pkg::OP_TEXT:  is_text  = accept;
            wbs_pkg::OP_CLEAR: is_clear = accept;
            default:           ;
        endcase
        room      = (load_len_reg < LEN_W'(MAX_WORD_LEN))
                    && (word_count_reg < CNT_W'(MAX_WORDS));
        store     = is_dict && room && !load_ovf_reg;
        ovf_after = load_ovf_reg || !room;
        len_after = load_len_reg + LEN_W'(store);
        commit    = is_dict && item.last && !ovf_after;

        word_count_next = word_count_reg;
        load_len_next   = load_len_reg;
        load_ovf_next   = load_ovf_reg;
        if (is_clear)
        begin
            word_count_next = '0;
            load_len_next   = '0;
            load_ovf_next   = 1'b0;
        end
        else if (is_dict)
        begin
            if (commit)
            begin
                word_count_next = word_count_reg + CNT_W'(1);
            end
            if (item.last)
            begin
                load_len_next = '0;
                load_ovf_next = 1'b0;
            end
            else
            begin
                load_len_next = len_after;
                load_ovf_next = ovf_after;
            end
        end
    end

    // loading state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_count_reg <= '0;
            load_len_reg   <= '0;
            load_ovf_reg   <= 1'b0;
        end
        else
        begin
            word_count_reg <= word_count_next;
            load_len_reg   <= load_len_next;
            load_ovf_reg   <= load_ovf_next;
        end
    end

    // text window after taking the new byte
    always_comb
    begin
        window[0] = item.symbol;
        for (int j = 1; j < MAX_WORD_LEN; j++)
        begin
            window[j] = text_q[j-1];
        end
        pos_ctrl.shift = is_text;
        pos_ctrl.clear = is_clear || (is_text && item.last);
    end

    // row of text position cells
    for (genvar j = 0; j < MAX_WORD_LEN; j++)
    begin : g_pos
        if (j == 0)
        begin : g_head
            wbs_pos_cell #(
                .START(1'b1)
            ) u_pos (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (pos_ctrl),
                .byte_in (item.symbol),
                .reach_in(reached),
                .byte_q  (text_q[j]),
                .reach_q (reach_q[j])
            );
        end
        else
        begin : g_body
            wbs_pos_cell #(
                .START(1'b0)
            ) u_pos (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctrl    (pos_ctrl),
                .byte_in (text_q[j-1]),
                .reach_in(reach_q[j-1]),
                .byte_q  (text_q[j]),
                .reach_q (reach_q[j])
            );
        end
    end

    // row of word cells, the slot being loaded is the one at word_count
    for (genvar w = 0; w < MAX_WORDS; w++)
    begin : g_word
        wbs_pkg::wbs_word_ctrl_t word_ctrl;

        always_comb
        begin
            word_ctrl.load   = store && (word_count_reg == CNT_W'(w));
            word_ctrl.commit = commit && (word_count_reg == CNT_W'(w));
            word_ctrl.clear  = is_clear;
        end

        wbs_word_cell #(
            .MAX_WORD_LEN(MAX_WORD_LEN)
        ) u_word (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (word_ctrl),
            .byte_in   (item.symbol),
            .commit_len(len_after),
            .window    (window),
            .reach     (reach_q),
            .hit       (hits[w])
        );
    end

    assign reached = |hits;

    // result forming and output register with skid stage
    always_comb
    begin
        new_res.prefix_breakable = is_text && reached;
        new_res.text_end         = is_text && item.last;
        new_res.dict_error       = is_dict && ovf_after;
        push                     = is_text || (is_dict && item.last);
        out_pop                  = out_vld_reg && result_ready;

        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (!out_vld_reg || out_pop)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_next     = new_res;
                skid_vld_next = push;
            end
            else
            begin
                out_next     = new_res;
                out_vld_next = push;
            end
        end
        else if (push)
        begin
            skid_next     = new_res;
            skid_vld_next = 1'b1;
        end
    end

    // output valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    // output payloads
    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign item_ready   = !skid_vld_reg;
    assign result_valid = out_vld_reg;
    assign result       = out_reg;

    // skid stage only fills behind a waiting result
    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid stage holds a result while the output is empty");

    // store never counts past its capacity
    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        word_count_reg <= CNT_W'(MAX_WORDS))
        else $error("word count beyond store size");

    // loading word never longer than a slot
    a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
        load_len_reg <= LEN_W'(MAX_WORD_LEN))
        else $error("loading length beyond slot size");

    // clear empties the store and the loading word
    a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
        is_clear |=> (word_count_reg == '0) && (load_len_reg == '0) && !load_ovf_reg)
        else $error("clear left dictionary state behind");

    // text end restores the start position
    a_text_restart : assert property (@(posedge clk) disable iff (!rst_n)
        (is_text && item.last) |=> (reach_q == MAX_WORD_LEN'(1)))
        else $error("text end did not restore start reachability");

endmodule

`default_nettype wire

// ----- tb/word_break_segmenter_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// word_break_segmenter_tb
// Self-checking bench for the word break segmenter. A short table of requests
// covers the extremes and the corner cases: an empty dictionary, a word of the
// greatest length, an over-long word, a full store, a clear part way through a
// word, the unused opcode, and a text whose words would need the bytes before
// its start. Random episodes follow. Each one loads words, then sends a text
// built mostly from those words. Clears, stray bytes and broken loads are
// mixed in. Every result is compared with a predictor that runs alongside, or with the expectation a table row gives.
// ============================================================================
`default_nettype none

module word_break_segmenter_tb;

    localparam int MAX_WORDS    = wbs_pkg::MAX_WORDS_DEF;
    localparam int MAX_WORD_LEN = wbs_pkg::MAX_WORD_LEN_DEF;

    // opcode that the block ignores
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS = 800;
    localparam int QUIET_FROM   = 700;

    // one row of the directed table
    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        symbol;
        logic              last;
        logic [4:0]        reps;
        logic              fixed;
        wbs_pkg::wbs_out_t res;
    } stim_row_t;

    localparam int STIM_ROWS = 35;
    localparam stim_row_t STIM_TABLE [STIM_ROWS] = '{
        // empty dictionary after reset
        '{wbs_pkg::OP_TEXT,  8'h61, 1'b0, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'hFF, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b0}},
        // extreme byte values as words
        '{wbs_pkg::OP_DICT,  8'h00, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'hFF, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'hFF, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h00, 1'b0, 5'd1,  1'b1, '{1'b1, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'hFF, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'hFF, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        // unused opcode is ignored
        '{OP_UNUSED,         8'h5A, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        // words "a" and "bc", text "abca" then "b" alone
        '{wbs_pkg::OP_DICT,  8'h61, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'h62, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'h63, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h61, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h62, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h63, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h61, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h62, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        // clear empties the dictionary
        '{wbs_pkg::OP_CLEAR, 8'hFF, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h61, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b1, 1'b0}},
        // clear part way through a word
        '{wbs_pkg::OP_DICT,  8'h78, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_CLEAR, 8'h00, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'h79, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h78, 1'b0, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h79, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        // word of the greatest length, then matched in the text
        '{wbs_pkg::OP_DICT,  8'h6D, 1'b0, 5'd15, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'h6D, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h6D, 1'b0, 5'd15, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_TEXT,  8'h6D, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}},
        // over-long word is dropped
        '{wbs_pkg::OP_DICT,  8'h7A, 1'b0, 5'd16, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'h7A, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b1}},
        // fill the store, then words are dropped
        '{wbs_pkg::OP_DICT,  8'h71, 1'b1, 5'd14, 1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'h72, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b1}},
        '{wbs_pkg::OP_DICT,  8'h72, 1'b0, 5'd2,  1'b0, '{1'b0, 1'b0, 1'b0}},
        '{wbs_pkg::OP_DICT,  8'h72, 1'b1, 5'd1,  1'b1, '{1'b0, 1'b0, 1'b1}},
        '{wbs_pkg::OP_TEXT,  8'h71, 1'b1, 5'd1,  1'b0, '{1'b0, 1'b0, 1'b0}}
    };

    logic              clk;
    logic              rst_n;
    logic              item_valid;
    logic              item_ready;
    wbs_pkg::wbs_in_t  item;
    logic              result_valid;
    logic              result_ready;
    wbs_pkg::wbs_out_t result;

    // typed expectation travelling with the request
    logic              item_fixed;
    wbs_pkg::wbs_out_t item_fixed_res;

    // predictor state
    logic [7:0] lex_chars [MAX_WORDS][MAX_WORD_LEN];
    int         lex_len [MAX_WORDS];
    int         lex_count;
    int         load_len;
    bit         load_ovf;
    logic [7:0] text_window [MAX_WORD_LEN];
    bit         reach [MAX_WORD_LEN + 1];

    wbs_pkg::wbs_out_t pending_results [$];
    int                mismatch_count;

    // words the stimulus has loaded, for building texts
    logic [7:0] vocab [MAX_WORDS][MAX_WORD_LEN];
    int         vocab_len [MAX_WORDS];
    int         vocab_n;
    int         random_items;
    bit         send_idle;
    bit         take_idle;

    word_break_segmenter #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2_000_000;
        $display("word_break_segmenter_tb failed");
        $finish;
    end

    // text state back to its start
    function automatic void restart_text();
        for (int k = 0; k < MAX_WORD_LEN; k++)
            text_window[k] = 8'h00;
        for (int k = 0; k <= MAX_WORD_LEN; k++)
            reach[k] = 1'b0;
        reach[0] = 1'b1;
    endfunction

    // segmentation predictor: returns 1 when the request yields a result
    function automatic bit segment_step(input wbs_pkg::wbs_in_t r,
                                        output wbs_pkg::wbs_out_t res);
        bit err;
        bit hit;
        bit same;
        int len;
        res = '0;
        case (r.opcode)
            wbs_pkg::OP_DICT:
            begin
                if (load_len >= MAX_WORD_LEN || lex_count >= MAX_WORDS)
                    load_ovf = 1'b1;
                else if (!load_ovf)
                begin
                    lex_chars[lex_count][load_len] = r.symbol;
                    load_len++;
                end
                if (!r.last)
                    return 1'b0;
                err = load_ovf || lex_count >= MAX_WORDS;
                if (!err)
                begin
                    lex_len[lex_count] = load_len;
                    lex_count++;
                end
                load_len = 0;
                load_ovf = 1'b0;
                res.dict_error = err;
                return 1'b1;
            end
            wbs_pkg::OP_TEXT:
            begin
                for (int k = MAX_WORD_LEN - 1; k > 0; k--)
                    text_window[k] = text_window[k - 1];
                text_window[0] = r.symbol;
                hit = 1'b0;
                for (int w = 0; w < lex_count && !hit; w++)
                begin
                    len = lex_len[w];
                    if (len > 0 && len <= MAX_WORD_LEN && reach[len - 1])
                    begin
                        same = 1'b1;
                        for (int m = 0; m < len; m++)
                            if (lex_chars[w][m] != text_window[len - 1 - m])
                                same = 1'b0;
                        hit = same;
                    end
                end
                for (int k = MAX_WORD_LEN; k > 0; k--)
                    reach[k] = reach[k - 1];
                reach[0] = hit;
                res.prefix_breakable = hit;
                res.text_end = r.last;
                if (r.last)
                    restart_text();
                return 1'b1;
            end
            wbs_pkg::OP_CLEAR:
            begin
                for (int w = 0; w < MAX_WORDS; w++)
                    lex_len[w] = 0;
                lex_count = 0;
                load_len = 0;
                load_ovf = 1'b0;
                restart_text();
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("%0t: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // predict on every accepted request, check every accepted result
    always @(posedge clk)
    begin : result_check
        wbs_pkg::wbs_out_t predicted;
        wbs_pkg::wbs_out_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
                if (segment_step(item, predicted))
                    pending_results.push_back(item_fixed ? item_fixed_res : predicted);
            if (result_valid && result_ready)
            begin
                if (pending_results.size() == 0)
                    flag_mismatch($sformatf("result %b with none expected", result));
                else
                begin
                    want = pending_results.pop_front();
                    if (result.prefix_breakable !== want.prefix_breakable)
                        flag_mismatch($sformatf("prefix_breakable %b, expected %b",
                            result.prefix_breakable, want.prefix_breakable));
                    if (result.text_end !== want.text_end)
                        flag_mismatch($sformatf("text_end %b, expected %b",
                            result.text_end, want.text_end));
                    if (result.dict_error !== want.dict_error)
                        flag_mismatch($sformatf("dict_error %b, expected %b",
                            result.dict_error, want.dict_error));
                end
            end
        end
    end

    // result side stalls in bursts
    initial
    begin
        result_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (take_idle && $urandom_range(0, 4) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    // one request, held until taken
    task automatic send_request(input logic [1:0] op, input logic [7:0] sym,
                                input logic last, input logic fixed = 1'b0,
                                input wbs_pkg::wbs_out_t fixed_res = '0);
        if (send_idle && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid     <= 1'b1;
        item           <= '{op, sym, last};
        item_fixed     <= fixed;
        item_fixed_res <= fixed_res;
        do
            @(posedge clk);
        while (!item_ready);
        if (op != OP_UNUSED)
            random_items++;
    endtask

    // hold off until every outstanding result has come back
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [7:0] pick_char();
        if ($urandom_range(0, 7) == 0)
            return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    task automatic send_clear();
        send_request(wbs_pkg::OP_CLEAR, 8'($urandom_range(0, 255)),
                     1'($urandom_range(0, 1)));
        vocab_n = 0;
    endtask

    // one dictionary word, now and then too long
    task automatic add_word();
        logic [7:0] spelling [MAX_WORD_LEN + 2];
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(MAX_WORD_LEN - 2, MAX_WORD_LEN + 2)
                                          : $urandom_range(1, 3);
        for (int m = 0; m < len; m++)
        begin
            spelling[m] = pick_char();
            send_request(wbs_pkg::OP_DICT, spelling[m], m == len - 1);
        end
        if (len <= MAX_WORD_LEN && vocab_n < MAX_WORDS)
        begin
            for (int m = 0; m < len; m++)
                vocab[vocab_n][m] = spelling[m];
            vocab_len[vocab_n] = len;
            vocab_n++;
        end
    endtask

    // text made mostly of loaded words, with stray bytes
    task automatic send_text();
        int  parts;
        int  idx;
        bit  closes;
        parts  = $urandom_range(1, 5);
        closes = $urandom_range(0, 3) != 0;
        for (int p = 0; p < parts; p++)
        begin
            if (vocab_n > 0 && $urandom_range(0, 7) != 0)
            begin
                idx = $urandom_range(0, vocab_n - 1);
                for (int m = 0; m < vocab_len[idx]; m++)
                    send_request(wbs_pkg::OP_TEXT, vocab[idx][m],
                                 closes && p == parts - 1 && m == vocab_len[idx] - 1);
            end
            else
                send_request(wbs_pkg::OP_TEXT, pick_char(), closes && p == parts - 1);
        end
    endtask

    task automatic run_episode();
        int n_words;
        send_idle = random_items < QUIET_FROM && $urandom_range(0, 3) != 0;
        take_idle = random_items < QUIET_FROM && $urandom_range(0, 3) != 0;
        if ($urandom_range(0, 5) == 0)
            send_clear();
        if ($urandom_range(0, 19) == 0)
            send_request(OP_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
        repeat (n_words) add_word();
        // broken load: bytes with no end, sometimes cleared away
        if ($urandom_range(0, 11) == 0)
        begin
            repeat ($urandom_range(1, 3)) send_request(wbs_pkg::OP_DICT, pick_char(), 1'b0);
            if ($urandom_range(0, 1) == 0)
                send_clear();
        end
        send_text();
        if ($urandom_range(0, 14) == 0)
            drain_results();
    endtask

    // stimulus
    initial
    begin
        rst_n          <= 1'b0;
        item_valid     <= 1'b0;
        item           <= '0;
        item_fixed     <= 1'b0;
        item_fixed_res <= '0;
        mismatch_count = 0;
        lex_count      = 0;
        load_len       = 0;
        load_ovf       = 1'b0;
        vocab_n        = 0;
        random_items   = 0;
        send_idle      = 1'b1;
        take_idle      = 1'b1;
        for (int w = 0; w < MAX_WORDS; w++)
        begin
            lex_len[w] = 0;
            for (int m = 0; m < MAX_WORD_LEN; m++)
                lex_chars[w][m] = 8'h00;
        end
        restart_text();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < STIM_ROWS; i++)
            for (int k = 0; k < STIM_TABLE[i].reps; k++)
                send_request(STIM_TABLE[i].opcode, STIM_TABLE[i].symbol, STIM_TABLE[i].last,
                             STIM_TABLE[i].fixed, STIM_TABLE[i].res);
        drain_results();

        // random episodes, quiet at the end
        send_clear();
        random_items = 0;
        while (random_items < RANDOM_ITEMS)
            run_episode();

        drain_results();
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatch_count == 0)
            $display("word_break_segmenter_tb passed");
        else
            $display("word_break_segmenter_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
